/* rtl/mpv_pkg.sv */
package mpv_pkg;

    localparam int MAX_ARTIFACTS = 64;
    localparam int COUNT_W = 7;

    localparam logic [1:0] REQ_ELEM = 2'd0;
    localparam logic [1:0] REQ_ROOT = 2'd1;
    localparam logic [1:0] REQ_ART  = 2'd2;
    localparam logic [1:0] REQ_FIN  = 2'd3;

    localparam logic [1:0] VERDICT_OK   = 2'd0;
    localparam logic [1:0] VERDICT_MISM = 2'd1;
    localparam logic [1:0] VERDICT_BAD  = 2'd2;

    // word store regions, upper address bits
    localparam logic [1:0] RG_ELEM = 2'd0;
    localparam logic [1:0] RG_ROOT = 2'd1;
    localparam logic [1:0] RG_RUN  = 2'd2;
    localparam logic [1:0] RG_SIB  = 2'd3;
    localparam int ZERO_ENTRIES = 24;

    localparam logic [63:0] ONES_WORD = 64'h0101010101010101;
    localparam logic [63:0] PAD_WORD  = 64'h8000000000000000;
    localparam logic [63:0] LEN_WORD  = 64'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_WRITE,
        ST_CMP,
        ST_RESULT
    } state_t;

    localparam logic [63:0] SHA_IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] SHA_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_s0(input logic [63:0] x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_s1(input logic [63:0] x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] small_s0(input logic [63:0] x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_s1(input logic [63:0] x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage

/* rtl/mpv_req_if.sv */
interface mpv_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [2:0]  word_index;
    logic [63:0] word_data;
    logic [7:0]  position_byte;

    modport source (output valid, req_type, word_index, word_data, position_byte,
                    input ready);
    modport sink   (input valid, req_type, word_index, word_data, position_byte,
                    output ready);
endinterface

/* rtl/mpv_rsp_if.sv */
interface mpv_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

/* rtl/merkle_proof_verifier_sha512_core.sv */
// Channel   Dir  Payload                                          Handshake
// req       in   req_type, word_index, word_data, position_byte  valid/ready
// rsp       out  verdict                                          valid/ready
//
// Element, root and plain artifact words are taken back to back from IDLE.
// The eighth word of an artifact (position 0 or 1) loads the block from the
// word store, then runs two SHA-512 compressions of 80 rounds on the single
// round unit, two chaining adds and 8 write-backs. Finish, unless a bad position
// was seen, makes 16 word-store reads (one read port). Reset clears all control state and
// the per-entry valid bits; no clearing pass. The result waits in an output
// register while new transactions are taken.
module merkle_proof_verifier_sha512_core
    import mpv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    mpv_req_if.sink  req,
    mpv_rsp_if.source rsp
);

    state_t state_reg, state_next;

    logic [63:0] mem [32];
    logic [63:0] mem_q_reg;
    logic        valid_bits_reg [ZERO_ENTRIES];
    logic        vq_reg;
    logic        rd_live_reg;
    logic        rd_side_reg;

    logic        rd_en;
    logic [4:0]  rd_addr;
    logic        we;
    logic [4:0]  wa;
    logic [63:0] wd;
    logic [63:0] rdata;

    logic [4:0]         cnt_reg;
    logic [6:0]         rnd_reg;
    logic               blk2_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ones_flag_reg;
    logic               bad_reg;
    logic               pos_reg;
    logic               ones_acc_reg;
    logic [63:0]        win_reg [16];
    logic [63:0]        v_reg [8];
    logic [63:0]        hv_reg [8];
    logic [63:0]        hold_reg;
    logic               mism_reg;
    logic               out_valid_reg;
    logic [1:0]         verdict_reg;

    logic        accept;
    logic        art_take;
    logic        fold_go;
    logic        use_elem;
    logic [1:0]  cur_rg;
    logic [1:0]  hsel_rg;
    logic [63:0] t1, t2, w_new;
    logic [2:0]  lw;

    assign accept   = req.valid && req.ready;
    assign art_take = !bad_reg && (count_reg < COUNT_W'(MAX_ARTIFACTS));
    assign fold_go  = accept && req.req_type == REQ_ART && art_take
                      && req.word_index == 3'd7 && req.position_byte <= 8'd1;
    assign use_elem = count_reg == '0 || (count_reg == COUNT_W'(1) && ones_flag_reg);
    assign cur_rg   = (count_reg == '0) ? RG_ELEM : RG_RUN;
    assign hsel_rg  = use_elem ? RG_ELEM : RG_RUN;
    assign rdata    = vq_reg ? mem_q_reg : 64'd0;
    assign lw       = cnt_reg[2:0];

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.verdict = verdict_reg;

    assign t1 = v_reg[7] + big_s1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + SHA_K[rnd_reg] + win_reg[0];
    assign t2 = big_s0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = small_s1(win_reg[14]) + win_reg[9] + small_s0(win_reg[1]) + win_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        we         = 1'b0;
        wa         = '0;
        wd         = req.word_data;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_ELEM:
                        begin
                            we = 1'b1;
                            wa = {RG_ELEM, req.word_index};
                        end
                        REQ_ROOT:
                        begin
                            we = 1'b1;
                            wa = {RG_ROOT, req.word_index};
                        end
                        REQ_ART:
                        begin
                            we = art_take;
                            wa = {RG_SIB, req.word_index};
                            if (fold_go)
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            state_next = bad_reg ? ST_RESULT : ST_CMP;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg < 5'd16)
                begin
                    rd_en = 1'b1;
                    // position 0: sibling first, position 1: current hash first
                    if (cnt_reg[3] == pos_reg)
                    begin
                        rd_addr = {RG_SIB, lw};
                    end
                    else
                    begin
                        rd_addr = {cur_rg, lw};
                    end
                end
                else
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 7'd79)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = blk2_reg ? ST_WRITE : ST_ROUND;
            end
            ST_WRITE:
            begin
                we = 1'b1;
                wa = {RG_RUN, lw};
                wd = hv_reg[lw];
                if (lw == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                if (cnt_reg < 5'd16)
                begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_reg[0] ? {RG_ROOT, cnt_reg[3:1]} : {hsel_rg, cnt_reg[3:1]};
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // word store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ZERO_ENTRIES; i++)
            begin
                valid_bits_reg[i] <= 1'b0;
            end
            vq_reg      <= 1'b0;
            rd_live_reg <= 1'b0;
            rd_side_reg <= 1'b0;
        end
        else
        begin
            if (we && wa < 5'(ZERO_ENTRIES))
            begin
                valid_bits_reg[wa] <= 1'b1;
            end
            if (rd_en)
            begin
                vq_reg <= (rd_addr < 5'(ZERO_ENTRIES)) ? valid_bits_reg[rd_addr] : 1'b1;
            end
            rd_live_reg <= rd_en;
            // marks a sibling word in LOAD, a root word in CMP
            if (state_reg == ST_LOAD)
            begin
                rd_side_reg <= rd_addr[4:3] == RG_SIB;
            end
            else
            begin
                rd_side_reg <= rd_addr[4:3] == RG_ROOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rnd_reg       <= '0;
            blk2_reg      <= 1'b0;
            count_reg     <= '0;
            ones_flag_reg <= 1'b1;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            mism_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg <= (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
            rnd_reg <= (state_reg == ST_ROUND && state_next == ST_ROUND) ? rnd_reg + 7'd1 : 7'd0;
            if (state_reg == ST_ADD)
            begin
                blk2_reg <= !blk2_reg;
            end
            if (accept && req.req_type == REQ_ELEM)
            begin
                count_reg     <= '0;
                ones_flag_reg <= 1'b1;
                bad_reg       <= 1'b0;
            end
            if (accept && req.req_type == REQ_ART && art_take && req.word_index == 3'd7
                && req.position_byte > 8'd1)
            begin
                bad_reg <= 1'b1;
            end
            if (state_reg == ST_WRITE && lw == 3'd7)
            begin
                count_reg     <= count_reg + COUNT_W'(1);
                ones_flag_reg <= ones_acc_reg;
            end
            if (state_reg == ST_IDLE && state_next == ST_CMP)
            begin
                mism_reg <= 1'b0;
            end
            else if (state_reg == ST_CMP && rd_live_reg && rd_side_reg && hold_reg != rdata)
            begin
                mism_reg <= 1'b1;
            end
            if (state_reg == ST_RESULT && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_go)
        begin
            pos_reg      <= req.position_byte[0];
            ones_acc_reg <= req.position_byte[0];
            for (int i = 0; i < 8; i++)
            begin
                hv_reg[i] <= SHA_IV[i];
                v_reg[i]  <= SHA_IV[i];
            end
        end
        if (state_reg == ST_LOAD && rd_live_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= rdata;
            if (rd_side_reg && rdata != ONES_WORD)
            begin
                ones_acc_reg <= 1'b0;
            end
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hv_reg[i] <= hv_reg[i] + v_reg[i];
                v_reg[i]  <= hv_reg[i] + v_reg[i];
            end
            // padding block for a 1024-bit message
            for (int i = 0; i < 16; i++)
            begin
                win_reg[i] <= 64'd0;
            end
            win_reg[0]  <= PAD_WORD;
            win_reg[15] <= LEN_WORD;
        end
        if (state_reg == ST_CMP && rd_live_reg && !rd_side_reg)
        begin
            hold_reg <= rdata;
        end
        if (state_reg == ST_RESULT && (!out_valid_reg || rsp.ready))
        begin
            verdict_reg <= bad_reg ? VERDICT_BAD : (mism_reg ? VERDICT_MISM : VERDICT_OK);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_ARTIFACTS))
        else $error("artifact count beyond bound");

    a_fold_starts: assert property (@(posedge clk) disable iff (!rst_n)
        fold_go |=> state_reg == ST_LOAD)
        else $error("fold did not start loading");

    a_no_write_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP || state_reg == ST_LOAD) |-> !we)
        else $error("word store written during read sweep");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.verdict != 2'd3)
        else $error("undefined verdict code");

endmodule

/* tb/sv/merkle_proof_verifier_sha512_core_tb.sv */
`timescale 1ns / 100ps

module merkle_proof_verifier_sha512_core_tb;
    import mpv_pkg::*;

    localparam int HOLD_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET = 1650;
    // items of the closing proof that saturates the artifact count
    localparam int SAT_ITEMS = 8 + (MAX_ARTIFACTS + 1) * 8 + 9;

    class proof_scoreboard;
        logic [63:0] run_hash [8];
        logic [63:0] elem_words [8];
        logic [63:0] root_store [8];
        logic [63:0] sib_words [8];
        int unsigned art_count;
        bit ones_seen;
        bit bad_pos;
        logic [1:0] verdict_q [$];
        int mismatches;

        function new();
            for (int i = 0; i < 8; i++)
            begin
                run_hash[i] = '0;
                elem_words[i] = '0;
                root_store[i] = '0;
                sib_words[i] = '0;
            end
            art_count = 0;
            ones_seen = 1'b1;
            bad_pos = 1'b0;
            mismatches = 0;
        endfunction

        function logic [63:0] ror(input logic [63:0] x, input int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress(inout logic [63:0] hv [8], input logic [63:0] blk [16]);
            logic [63:0] w [16];
            logic [63:0] v [8];
            logic [63:0] t1, t2, a, b;
            for (int i = 0; i < 16; i++)
                w[i] = blk[i];
            for (int i = 0; i < 8; i++)
                v[i] = hv[i];
            for (int t = 0; t < 80; t++)
            begin
                if (t >= 16)
                begin
                    a = w[(t - 15) & 15];
                    b = w[(t - 2) & 15];
                    w[t & 15] = w[t & 15] + (ror(b, 19) ^ ror(b, 61) ^ (b >> 6))
                              + w[(t - 7) & 15] + (ror(a, 1) ^ ror(a, 8) ^ (a >> 7));
                end
                t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t & 15];
                t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hv[i] = hv[i] + v[i];
        endfunction

        function void fold(input logic [7:0] pos);
            logic [63:0] blk [16];
            logic [63:0] hv [8];
            logic [63:0] cur [8];
            bit ones;
            ones = (pos == 8'd1);
            for (int i = 0; i < 8; i++)
            begin
                cur[i] = (art_count == 0) ? elem_words[i] : run_hash[i];
                if (sib_words[i] != ONES_WORD)
                    ones = 1'b0;
                blk[i] = (pos == 8'd0) ? sib_words[i] : cur[i];
                blk[8 + i] = (pos == 8'd0) ? cur[i] : sib_words[i];
                hv[i] = SHA_IV[i];
            end
            compress(hv, blk);
            for (int i = 0; i < 16; i++)
                blk[i] = '0;
            blk[0] = PAD_WORD;
            blk[15] = LEN_WORD;
            compress(hv, blk);
            for (int i = 0; i < 8; i++)
                run_hash[i] = hv[i];
            ones_seen = ones;
            art_count++;
        endfunction

        // hash that a finish would compare against the root
        function void compared_hash(output logic [63:0] h [8]);
            bit use_elem;
            use_elem = (art_count == 0) || (art_count == 1 && ones_seen);
            for (int i = 0; i < 8; i++)
                h[i] = use_elem ? elem_words[i] : run_hash[i];
        endfunction

        function void note_request(input logic [1:0] rt, input logic [2:0] idx,
                                   input logic [63:0] data, input logic [7:0] pos);
            logic [63:0] h [8];
            logic [1:0] v;
            case (rt)
                REQ_ELEM:
                begin
                    elem_words[idx] = data;
                    art_count = 0;
                    ones_seen = 1'b1;
                    bad_pos = 1'b0;
                end
                REQ_ROOT:
                    root_store[idx] = data;
                REQ_ART:
                begin
                    if (!bad_pos && art_count < MAX_ARTIFACTS)
                    begin
                        sib_words[idx] = data;
                        if (idx == 3'd7)
                        begin
                            if (pos > 8'd1)
                                bad_pos = 1'b1;
                            else
                                fold(pos);
                        end
                    end
                end
                default:
                begin
                    if (bad_pos)
                        v = VERDICT_BAD;
                    else
                    begin
                        compared_hash(h);
                        v = VERDICT_OK;
                        for (int i = 0; i < 8; i++)
                            if (h[i] != root_store[i])
                                v = VERDICT_MISM;
                    end
                    verdict_q.push_back(v);
                end
            endcase
        endfunction

        function void check_verdict(input logic [1:0] got);
            logic [1:0] want;
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected verdict %0d", got);
                return;
            end
            want = verdict_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: verdict expected %0d actual %0d", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    mpv_req_if req ();
    mpv_rsp_if rsp ();

    merkle_proof_verifier_sha512_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    proof_scoreboard sb;
    int sent_items;
    bit calm;
    bit hold_off;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_req(input logic [1:0] rt, input logic [2:0] idx,
                            input logic [63:0] data, input logic [7:0] pos);
        bit took;
        req.valid <= 1'b1;
        req.req_type <= rt;
        req.word_index <= idx;
        req.word_data <= data;
        req.position_byte <= pos;
        // sample ready mid-cycle, where it is settled for the coming edge
        do
        begin
            @(negedge clk);
            took = req.ready;
            @(posedge clk);
        end
        while (!took);
        sb.note_request(rt, idx, data, pos);
        sent_items++;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // root_mode: 0 matching root, 1 one flipped bit, 2 random
    task automatic run_proof(input int n_art, input int bad_at, input bit ones_case,
                             input int root_mode);
        logic [63:0] h [8];
        logic [7:0] pos;
        int flip;
        for (int i = 0; i < 8; i++)
            send_req(REQ_ELEM, i[2:0], rand_word(), 8'($urandom));
        for (int a = 0; a < n_art; a++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                pos = 8'($urandom);
                if (i == 7)
                begin
                    if (a == bad_at)
                        pos = 8'($urandom_range(2, 255));
                    else if (ones_case)
                        pos = 8'd1;
                    else
                        pos = 8'($urandom_range(0, 1));
                end
                send_req(REQ_ART, i[2:0], ones_case ? ONES_WORD : rand_word(), pos);
            end
        end
        sb.compared_hash(h);
        flip = $urandom_range(0, 511);
        for (int i = 0; i < 8; i++)
        begin
            if (root_mode == 1 && flip / 64 == i)
                h[i][flip % 64] = ~h[i][flip % 64];
            else if (root_mode == 2)
                h[i] = rand_word();
            send_req(REQ_ROOT, i[2:0], h[i], 8'($urandom));
        end
        send_req(REQ_FIN, 3'($urandom), rand_word(), 8'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_req(REQ_FIN, 3'($urandom), rand_word(), 8'($urandom));
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                sb.check_verdict(rsp.verdict);
            if (hold_off)
            begin
                hold_off = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int mode;
        sb = new();
        sent_items = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_ELEM;
        req.word_index = '0;
        req.word_data = '0;
        req.position_byte = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: zero element against zero root
        send_req(REQ_FIN, 3'd0, '0, 8'd0);
        // first artifact writes every sibling word, in order
        run_proof(1, -1, 1'b0, 0);
        run_proof(1, -1, 1'b1, 0);
        run_proof(0, -1, 1'b0, 1);
        run_proof(2, 1, 1'b0, 0);

        hold_off = 1'b1;
        while (sent_items < ITEM_TARGET - SAT_ITEMS)
        begin
            if (sent_items > ITEM_TARGET - SAT_ITEMS - 100)
                calm = 1'b1;
            mode = $urandom_range(0, 19);
            if (mode < 13)
                run_proof($urandom_range(0, 4), -1, 1'b0, $urandom_range(0, 2));
            else if (mode < 15)
                run_proof($urandom_range(1, 3), $urandom_range(0, 2), 1'b0,
                          $urandom_range(0, 2));
            else if (mode < 17)
                run_proof($urandom_range(1, 2), -1, 1'b1, $urandom_range(0, 1));
            else
            begin
                // noise: loose items of every kind
                repeat ($urandom_range(1, 12))
                    send_req(2'($urandom), 3'($urandom), rand_word(), 8'($urandom));
            end
        end
        // saturate the artifact count once for sure
        calm = 1'b1;
        run_proof(MAX_ARTIFACTS + 1, -1, 1'b0, 0);
        req.valid <= 1'b0;

        while (sb.verdict_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.mismatches == 0 && sb.verdict_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
